@@ hw/rtl/spdk_pkg.sv @@
package spdk_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned OutCntW    = 5;
  localparam int unsigned WordW      = 32;

  typedef enum logic {
    CmdPush   = 1'b0,
    CmdDelete = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFin
  } state_e;

  typedef struct packed {
    logic                    command;
    logic signed [WordW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [OutCntW-1:0]      depth_after;
    logic [OutCntW-1:0]      removed_count;
    logic                    overflow;
    logic signed [WordW-1:0] top_value;
    logic                    is_empty;
  } out_t;

  typedef struct packed {
    logic                    we;
    logic [AddrW-1:0]        waddr;
    logic signed [WordW-1:0] wdata;
    logic                    re;
    logic [AddrW-1:0]        raddr;
  } ram_req_t;

endpackage

@@ hw/rtl/spdk_ram.sv @@
module spdk_ram (
  input  logic                            clk_i,
  input  spdk_pkg::ram_req_t              req_i,
  output logic signed [spdk_pkg::WordW-1:0] rdata_o
);

  logic signed [spdk_pkg::WordW-1:0] mem_q [spdk_pkg::StackDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

@@ hw/rtl/stack_push_delete_key_unit.sv @@
// LIFO stack of signed 32-bit words with push and delete-by-key.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries a command and a
// value; output channel (out_valid_o / out_ready_i / out_data_o) returns one
// result per input transfer: depth, removed count, overflow, top and empty.
// One item is handled at a time; in_ready_o is high only while the sequencer
// is idle. A push writes the store at the transfer and passes to the finish
// state, where its result is registered once the output register is free. A
// delete walks the held entries through one memory read port and one
// comparator, one entry per cycle, writing kept entries back in place, then
// passes to the finish state. The next item can be taken in the cycle after
// the result is registered.
// The result sits in an output register; a new item may be taken while it
// waits, and the next result is held back until the receiver takes the
// previous one, so a stalled receiver stalls the block only at completion.
// Reset empties the stack (entry count zero) and clears the output valid;
// store contents are not cleared.
module stack_push_delete_key_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spdk_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spdk_pkg::out_t    out_data_o
);

  spdk_pkg::state_e state_q, state_d;

  logic [spdk_pkg::CntW-1:0]         cnt_q, rd_q, wr_q, removed_q;
  logic                              cmp_vld_q, ovf_q, out_vld_q;
  logic signed [spdk_pkg::WordW-1:0] key_q, top_q, rdata;
  spdk_pkg::ram_req_t                ram_req;
  spdk_pkg::out_t                    out_q;

  logic full, in_xfer, is_push, keep, walk_done, slot_free;

  assign full      = (cnt_q == spdk_pkg::CntW'(spdk_pkg::StackDepth));
  assign in_xfer   = in_valid_i && in_ready_o;
  assign is_push   = (in_data_i.command == spdk_pkg::CmdPush);
  assign keep      = cmp_vld_q && (rdata != key_q);
  assign walk_done = (rd_q == cnt_q) && !cmp_vld_q;
  assign slot_free = !out_vld_q || out_ready_i;

  spdk_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spdk_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = is_push ? spdk_pkg::StFin : spdk_pkg::StWalk;
        end
      end
      spdk_pkg::StWalk: begin
        if (walk_done) state_d = spdk_pkg::StFin;
      end
      spdk_pkg::StFin: begin
        if (slot_free) state_d = spdk_pkg::StIdle;
      end
      default: state_d = spdk_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = cnt_q[spdk_pkg::AddrW-1:0];
    ram_req.wdata = in_data_i.value;
    ram_req.re    = 1'b0;
    ram_req.raddr = rd_q[spdk_pkg::AddrW-1:0];
    unique case (state_q)
      spdk_pkg::StIdle: begin
        in_ready_o = 1'b1;
        ram_req.we = in_valid_i && is_push && !full;
      end
      spdk_pkg::StWalk: begin
        ram_req.re    = (rd_q < cnt_q);
        ram_req.we    = keep;
        ram_req.waddr = wr_q[spdk_pkg::AddrW-1:0];
        ram_req.wdata = rdata;
      end
      spdk_pkg::StFin: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spdk_pkg::StIdle;
      cnt_q     <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == spdk_pkg::StFin) && slot_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        spdk_pkg::StIdle: begin
          if (in_xfer) begin
            rd_q      <= '0;
            wr_q      <= '0;
            cmp_vld_q <= 1'b0;
            if (is_push && !full) cnt_q <= cnt_q + 1'b1;
          end
        end
        spdk_pkg::StWalk: begin
          cmp_vld_q <= ram_req.re;
          if (ram_req.re) rd_q <= rd_q + 1'b1;
          if (keep) wr_q <= wr_q + 1'b1;
          if (walk_done) cnt_q <= wr_q;
        end
        spdk_pkg::StFin: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      spdk_pkg::StIdle: begin
        if (in_xfer) begin
          key_q     <= in_data_i.value;
          removed_q <= '0;
          ovf_q     <= is_push && full;
          if (is_push && !full) top_q <= in_data_i.value;
        end
      end
      spdk_pkg::StWalk: begin
        if (keep) top_q <= rdata;
        if (walk_done) removed_q <= cnt_q - wr_q;
      end
      spdk_pkg::StFin: begin
        if (slot_free) begin
          out_q.depth_after   <= spdk_pkg::OutCntW'(cnt_q);
          out_q.removed_count <= spdk_pkg::OutCntW'(removed_q);
          out_q.overflow      <= ovf_q;
          out_q.top_value     <= (cnt_q == '0) ? '0 : top_q;
          out_q.is_empty      <= (cnt_q == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/spdk_checker.sv @@
module spdk_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input spdk_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input spdk_pkg::out_t out_data_o
);

  // not ready in the cycle after every input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.depth_after == '0)))
    else $error("empty flag disagrees with depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> (out_data_o.top_value == '0))
    else $error("top not zero on empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> (out_data_o.removed_count == '0))
    else $error("overflow reported with removals");

endmodule

bind stack_push_delete_key_unit spdk_checker u_spdk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ sim/stack_push_delete_key_unit_test.sv @@
`timescale 1ns / 100ps

class stack_mirror;
  logic signed [spdk_pkg::WordW-1:0] words [spdk_pkg::StackDepth];
  int unsigned                       held;
  spdk_pkg::out_t                    pending_results [$];
  int unsigned                       errors;

  function new();
    held   = 0;
    errors = 0;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  function void note_transfer(spdk_pkg::in_t item);
    spdk_pkg::out_t res;
    int unsigned    kept;
    res  = '0;
    kept = 0;
    if (item.command == spdk_pkg::CmdPush) begin
      if (held < spdk_pkg::StackDepth) begin
        words[held] = item.value;
        held++;
      end else begin
        res.overflow = 1'b1;
      end
    end else begin
      for (int unsigned i = 0; i < held; i++) begin
        if (words[i] != item.value) begin
          words[kept] = words[i];
          kept++;
        end
      end
      res.removed_count = spdk_pkg::OutCntW'(held - kept);
      held = kept;
    end
    res.depth_after = spdk_pkg::OutCntW'(held);
    res.top_value   = (held != 0) ? words[held-1] : '0;
    res.is_empty    = (held == 0);
    pending_results.push_back(res);
  endfunction

  function void check_result(spdk_pkg::out_t got);
    spdk_pkg::out_t want;
    bit             bad;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer: %p", got);
      return;
    end
    want = pending_results.pop_front();
    bad  = (got.depth_after !== want.depth_after) ||
           (got.removed_count !== want.removed_count) ||
           (got.overflow !== want.overflow) ||
           (got.top_value !== want.top_value) ||
           (got.is_empty !== want.is_empty);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display({"mismatch: depth %0d/%0d removed %0d/%0d ovf %0b/%0b",
                  " top %0d/%0d empty %0b/%0b"},
                 want.depth_after, got.depth_after, want.removed_count, got.removed_count,
                 want.overflow, got.overflow, want.top_value, got.top_value,
                 want.is_empty, got.is_empty);
      end
    end
  endfunction
endclass

module stack_push_delete_key_unit_test;

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  spdk_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  spdk_pkg::out_t out_data_o;

  stack_mirror board = new();

  bit          quiet    = 1'b0;
  int unsigned idle_pct = 20;
  int unsigned push_pct = 60;
  logic [31:0] key_pool [6];

  stack_push_delete_key_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_transfer(in_data_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // receiver: stall bursts mixed with long ready stretches
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic send_item(input spdk_pkg::cmd_e cmd, input logic [31:0] word);
    spdk_pkg::in_t item;
    item.command = cmd;
    item.value   = word;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = 32'h8000_0000;
        1:       key_pool[i] = 32'h7fff_ffff;
        2:       key_pool[i] = 32'h0000_0000;
        3:       key_pool[i] = 32'hffff_ffff;
        default: key_pool[i] = $urandom();
      endcase
    end
  endtask

  initial begin
    logic [31:0]    word;
    spdk_pkg::cmd_e cmd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // delete on empty, extremes, no-match delete, fill, overflow, multi-match deletes
    send_item(spdk_pkg::CmdDelete, 32'd5);
    send_item(spdk_pkg::CmdPush, 32'h8000_0000);
    send_item(spdk_pkg::CmdPush, 32'h7fff_ffff);
    send_item(spdk_pkg::CmdPush, 32'h0000_0000);
    send_item(spdk_pkg::CmdPush, 32'hffff_ffff);
    send_item(spdk_pkg::CmdDelete, 32'd12345);
    for (int i = 0; i < 12; i++) begin
      send_item(spdk_pkg::CmdPush, (i % 3 == 0) ? 32'h7fff_ffff : i);
    end
    send_item(spdk_pkg::CmdPush, 32'd42);
    send_item(spdk_pkg::CmdPush, 32'h8000_0000);
    send_item(spdk_pkg::CmdDelete, 32'h7fff_ffff);
    send_item(spdk_pkg::CmdDelete, 32'hffff_ffff);
    send_item(spdk_pkg::CmdDelete, 32'h8000_0000);
    send_item(spdk_pkg::CmdDelete, 32'h0000_0000);

    for (int n = 0; n < 1950; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 30;
          1:       push_pct = 50;
          2:       push_pct = 70;
          default: push_pct = 90;
        endcase
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 30;
          default: idle_pct = 60;
        endcase
        refresh_pool();
      end
      if (n == 1650) quiet = 1'b1;
      if ($urandom_range(0, 9) < 6) word = key_pool[$urandom_range(0, 5)];
      else word = $urandom();
      if ($urandom_range(0, 99) < push_pct) cmd = spdk_pkg::CmdPush;
      else cmd = spdk_pkg::CmdDelete;
      send_item(cmd, word);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (spdk_pkg::StackDepth + 8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[stack_push_delete_key_unit] OK");
    end else begin
      $display("[stack_push_delete_key_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[stack_push_delete_key_unit] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/spdk_pkg.sv
hw/rtl/spdk_ram.sv
hw/rtl/stack_push_delete_key_unit.sv
hw/rtl/spdk_checker.sv
sim/stack_push_delete_key_unit_test.sv
